// ===== src/epc_pkg.sv =====
`default_nettype none

package epc_pkg;

  // matrix row register width, three packed entries
  localparam int ROW_W = 54;
  // normalized magnitude width, top bit lands at 2^(NORM_W-1)
  localparam int NORM_W = 30;
  // configuration port widths
  localparam int CFG_DW = 64;
  localparam int CFG_AW = 5;

  typedef enum logic [1:0] {
    REG_ROW0  = 2'd0,
    REG_ROW1  = 2'd1,
    REG_ROW2  = 2'd2,
    REG_SIGMA = 2'd3
  } epc_reg_e;

  // per-lane status travelling beside the term value
  typedef struct packed {
    logic vld;
    logic degen;
  } epc_flag_t;

endpackage

`default_nettype wire

// ===== src/epc_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per register stage
module epc_div #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int QW = 8,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [SW-1:0] side_q [QW];
  logic          vld_q  [QW];

  for (genvar g = 0; g < QW; g++) begin : g_step
    localparam int K = QW - 1 - g;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [SW-1:0] side_in;
    logic          vld_in;
    logic [CW-1:0] trial;
    logic [CW-1:0] rem_ext;
    logic          fits;

    if (g == 0) begin : g_first
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign den_in  = den_q[g-1];
      assign quo_in  = quo_q[g-1];
      assign side_in = side_q[g-1];
      assign vld_in  = vld_q[g-1];
    end

    // trial subtract of the shifted divisor
    assign trial   = CW'(den_in) << K;
    assign rem_ext = CW'(rem_in);
    assign fits    = rem_ext >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g]  <= fits ? NW'(rem_ext - trial) : rem_in;
      den_q[g]  <= den_in;
      quo_q[g]  <= quo_in | (fits ? (QW'(1) << K) : QW'(0));
      side_q[g] <= side_in;
    end
  end

  assign vld_o  = vld_q[QW-1];
  assign quo_o  = quo_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

`default_nettype wire

// ===== src/epc_sqrt.sv =====
`default_nettype none

// floor integer square root, one root bit per register stage
module epc_sqrt #(
  parameter int VW = 62,
  parameter int RW = 31,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  logic [VW-1:0] val_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [RW-1:0] root_o,
  output logic [SW-1:0] side_o
);

  localparam int CW = (VW > 2 * RW ? VW : 2 * RW) + 1;

  logic [VW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [SW-1:0] side_q [RW];
  logic          vld_q  [RW];

  for (genvar g = 0; g < RW; g++) begin : g_step
    localparam int I = RW - 1 - g;
    logic [VW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [SW-1:0] side_in;
    logic          vld_in;
    logic [CW-1:0] trial;
    logic [CW-1:0] rem_ext;
    logic          fits;

    if (g == 0) begin : g_first
      assign rem_in  = val_i;
      assign root_in = '0;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign side_in = side_q[g-1];
      assign vld_in  = vld_q[g-1];
    end

    // (root + 2^i)^2 - root^2, root holds only bits above i
    assign trial   = (CW'(root_in) << (I + 1)) | (CW'(1) << (2 * I));
    assign rem_ext = CW'(rem_in);
    assign fits    = rem_ext >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g]  <= fits ? VW'(rem_ext - trial) : rem_in;
      root_q[g] <= root_in | (fits ? (RW'(1) << I) : RW'(0));
      side_q[g] <= side_in;
    end
  end

  assign vld_o  = vld_q[RW-1];
  assign root_o = root_q[RW-1];
  assign side_o = side_q[RW-1];

endmodule

`default_nettype wire

// ===== src/epc_proj.sv =====
`default_nettype none

// both matrix projections: products stage, then sums stage
module epc_proj import epc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      vld_i,
  input  logic signed [FRAC_BITS+1:0]   p1_i [3],
  input  logic signed [FRAC_BITS+1:0]   p2_i [3],
  input  logic        [ROW_W-1:0]       row_i [3],
  output logic                      vld_o,
  output logic signed [2*FRAC_BITS+4:0] q1_o [3],
  output logic signed [2*FRAC_BITS+4:0] q2_o [3],
  output logic signed [FRAC_BITS+1:0]   p1_o [3],
  output logic signed [FRAC_BITS+1:0]   p2_o [3]
);

  localparam int W  = FRAC_BITS + 2;
  localparam int PW = 2 * W;
  localparam int QW = 2 * W + 1;
  localparam int RX = (3 * W > ROW_W) ? 3 * W : ROW_W;

  logic        [RX-1:0] rowx [3];
  logic signed [W-1:0]  m    [3][3];

  logic signed [PW-1:0] pr1_q [3][3];
  logic signed [PW-1:0] pr2_q [3][3];
  logic signed [W-1:0]  p1a_q [3];
  logic signed [W-1:0]  p2a_q [3];
  logic signed [QW-1:0] q1_q  [3];
  logic signed [QW-1:0] q2_q  [3];
  logic signed [W-1:0]  p1b_q [3];
  logic signed [W-1:0]  p2b_q [3];
  logic                 vlda_q;
  logic                 vldb_q;

  // unpack matrix entries, column 0 in the low bits
  for (genvar r = 0; r < 3; r++) begin : g_row
    assign rowx[r] = RX'(row_i[r]);
    for (genvar c = 0; c < 3; c++) begin : g_col
      assign m[r][c] = $signed(rowx[r][c*W +: W]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlda_q <= 1'b0;
      vldb_q <= 1'b0;
    end else begin
      vlda_q <= vld_i;
      vldb_q <= vlda_q;
    end
  end

  // row vector times matrix and matrix times column vector
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pr1_q[i][j] <= PW'(p1_i[j]) * PW'(m[j][i]);
        pr2_q[i][j] <= PW'(m[i][j]) * PW'(p2_i[j]);
      end
    end
    p1a_q <= p1_i;
    p2a_q <= p2_i;
  end

  // exact sums of the three products
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      q1_q[i] <= QW'(pr1_q[i][0]) + QW'(pr1_q[i][1]) + QW'(pr1_q[i][2]);
      q2_q[i] <= QW'(pr2_q[i][0]) + QW'(pr2_q[i][1]) + QW'(pr2_q[i][2]);
    end
    p1b_q <= p1a_q;
    p2b_q <= p2a_q;
  end

  assign vld_o = vldb_q;
  assign q1_o  = q1_q;
  assign q2_o  = q2_q;
  assign p1_o  = p1b_q;
  assign p2_o  = p2b_q;

endmodule

`default_nettype wire

// ===== src/epc_term.sv =====
`default_nettype none

// one residual term |q.p| / |q| with q normalized
module epc_term import epc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      vld_i,
  input  logic signed [2*FRAC_BITS+4:0] q_i [3],
  input  logic signed [FRAC_BITS+1:0]   p_i [3],
  output epc_flag_t                 flag_o,
  output logic        [FRAC_BITS+3:0]   term_o
);

  localparam int W    = FRAC_BITS + 2;
  localparam int QW   = 2 * W + 1;
  localparam int MW   = 2 * W;
  localparam int AW   = (MW > NORM_W) ? MW : NORM_W;
  localparam int PAD  = AW - MW;
  localparam int NS   = $clog2(AW);
  localparam int SQW  = 2 * NORM_W;
  localparam int VW   = 2 * NORM_W + 2;
  localparam int RW   = NORM_W + 1;
  localparam int PRW  = NORM_W + 1 + W;
  localparam int DOTW = NORM_W + W + 2;
  localparam int DTW  = DOTW - 1;
  localparam int TW   = W + 2;

  // magnitude stage
  logic [MW-1:0]        mag_c [3];
  logic [AW-1:0]        al_q  [3];
  logic [2:0]           neg_q;
  logic                 deg_q;
  logic signed [W-1:0]  pc_q  [3];
  logic                 vldc_q;

  // normalize stages
  logic [AW-1:0]        nal_q  [NS][3];
  logic [2:0]           nneg_q [NS];
  logic                 ndeg_q [NS];
  logic signed [W-1:0]  np_q   [NS][3];
  logic                 nvld_q [NS];

  // square and dot stages
  logic [NORM_W-1:0]    nm_c  [3];
  logic signed [NORM_W:0] sp_c [3];
  logic [SQW-1:0]       sq_q  [3];
  logic signed [PRW-1:0] pr_q [3];
  logic                 mdeg_q;
  logic                 vldm_q;
  logic [VW-1:0]        n2_q;
  logic signed [DOTW-1:0] dot_c;
  logic [DTW-1:0]       adot_q;
  logic                 sdeg_q;
  logic                 vlds_q;

  // root and divide
  logic                 rt_vld;
  logic [RW-1:0]        rt_len;
  logic [DTW:0]         rt_side;
  logic                 dv_vld;
  logic [TW-1:0]        dv_quo;
  logic                 dv_deg;

  for (genvar k = 0; k < 3; k++) begin : g_mag
    assign mag_c[k] = q_i[k][QW-1] ? MW'(-q_i[k]) : MW'(q_i[k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldc_q <= 1'b0;
      vldm_q <= 1'b0;
      vlds_q <= 1'b0;
    end else begin
      vldc_q <= vld_i;
      vldm_q <= nvld_q[NS-1];
      vlds_q <= vldm_q;
    end
  end

  // sign and magnitude, left-justified in the shift word
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      al_q[k]  <= AW'(mag_c[k]) << PAD;
      neg_q[k] <= q_i[k][QW-1];
    end
    deg_q <= (q_i[0] == '0) && (q_i[1] == '0) && (q_i[2] == '0);
    pc_q  <= p_i;
  end

  // common left shift until the largest magnitude reaches the top bit
  for (genvar s = 0; s < NS; s++) begin : g_norm
    localparam int S = 1 << (NS - 1 - s);
    logic [AW-1:0]       in_al [3];
    logic [2:0]          in_neg;
    logic                in_deg;
    logic signed [W-1:0] in_p  [3];
    logic                in_vld;
    logic [AW-1:0]       orw;
    logic                sh;

    if (s == 0) begin : g_first
      assign in_al  = al_q;
      assign in_neg = neg_q;
      assign in_deg = deg_q;
      assign in_p   = pc_q;
      assign in_vld = vldc_q;
    end else begin : g_next
      assign in_al  = nal_q[s-1];
      assign in_neg = nneg_q[s-1];
      assign in_deg = ndeg_q[s-1];
      assign in_p   = np_q[s-1];
      assign in_vld = nvld_q[s-1];
    end

    assign orw = in_al[0] | in_al[1] | in_al[2];
    assign sh  = (orw[AW-1 -: S] == '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nvld_q[s] <= 1'b0;
      end else begin
        nvld_q[s] <= in_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      for (int k = 0; k < 3; k++) begin
        nal_q[s][k] <= sh ? (in_al[k] << S) : in_al[k];
      end
      nneg_q[s] <= in_neg;
      ndeg_q[s] <= in_deg;
      np_q[s]   <= in_p;
    end
  end

  // top bits of the shift word give the truncated normalized magnitude
  for (genvar k = 0; k < 3; k++) begin : g_nm
    assign nm_c[k] = nal_q[NS-1][k][AW-1 -: NORM_W];
    assign sp_c[k] = nneg_q[NS-1][k] ? -$signed({1'b0, nm_c[k]}) : $signed({1'b0, nm_c[k]});
  end

  // squares and signed products with the other direction
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      sq_q[k] <= SQW'(nm_c[k]) * SQW'(nm_c[k]);
      pr_q[k] <= PRW'(sp_c[k]) * PRW'(np_q[NS-1][k]);
    end
    mdeg_q <= ndeg_q[NS-1];
  end

  // squared length and absolute dot product
  assign dot_c = DOTW'(pr_q[0]) + DOTW'(pr_q[1]) + DOTW'(pr_q[2]);

  always_ff @(posedge clk_i) begin
    n2_q   <= VW'(sq_q[0]) + VW'(sq_q[1]) + VW'(sq_q[2]);
    adot_q <= dot_c[DOTW-1] ? DTW'(-dot_c) : DTW'(dot_c);
    sdeg_q <= mdeg_q;
  end

  epc_sqrt #(
    .VW (VW),
    .RW (RW),
    .SW (DTW + 1)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vlds_q),
    .val_i  (n2_q),
    .side_i ({sdeg_q, adot_q}),
    .vld_o  (rt_vld),
    .root_o (rt_len),
    .side_o (rt_side)
  );

  epc_div #(
    .NW (DTW),
    .DW (RW),
    .QW (TW),
    .SW (1)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (rt_vld),
    .num_i  (rt_side[DTW-1:0]),
    .den_i  (rt_len),
    .side_i (rt_side[DTW]),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo),
    .side_o (dv_deg)
  );

  assign flag_o.vld   = dv_vld;
  assign flag_o.degen = dv_deg;
  assign term_o       = dv_quo;

endmodule

`default_nettype wire

// ===== src/epipolar_pair_cost.sv =====
`default_nettype none

// channel   | handshake                          | payload
// item in   | start, busy (accepted start & !busy) | first_dir_*_i, second_dir_*_i
// result    | done_o, one cycle, no backpressure | pair_cost_o, degenerate_o
// config    | psel, penable, pwrite, pready      | paddr, pwdata, prdata
//
// one item per cycle; busy stays low, the pipeline never stalls
// an item passes the projection, magnitude, normalize, square, dot, square root,
// term divide, combine, softening operand, softening divide and result stages; the
// bit-per-stage square root and the two restoring divider pipelines set most of the depth
// reset clears the configuration registers and every valid bit
// each result shows on the ports for one cycle and must be taken then
module epipolar_pair_cost import epc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [FRAC_BITS+1:0] first_dir_x_i,
  input  logic signed [FRAC_BITS+1:0] first_dir_y_i,
  input  logic signed [FRAC_BITS+1:0] first_dir_z_i,
  input  logic signed [FRAC_BITS+1:0] second_dir_x_i,
  input  logic signed [FRAC_BITS+1:0] second_dir_y_i,
  input  logic signed [FRAC_BITS+1:0] second_dir_z_i,
  output logic                      done_o,
  output logic        [FRAC_BITS:0] pair_cost_o,
  output logic                      degenerate_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic        [CFG_AW-1:0]  paddr,
  input  logic        [CFG_DW-1:0]  pwdata,
  output logic        [CFG_DW-1:0]  prdata,
  output logic                      pready
);

  localparam int W   = FRAC_BITS + 2;
  localparam int QW  = 2 * W + 1;
  localparam int TW  = W + 2;
  localparam int CW  = FRAC_BITS + 1;
  localparam int MW  = 2 * W;
  localparam int AW  = (MW > NORM_W) ? MW : NORM_W;
  localparam int NS  = $clog2(AW);
  localparam int LAT = 2 + 1 + NS + 2 + (NORM_W + 1) + TW + 2 + CW + 1;
  localparam logic [CW-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  // configuration
  logic [ROW_W-1:0] row_q [3];
  logic [CW-1:0]    sigma_q;
  logic             cfg_wr;
  epc_reg_e         cfg_idx;

  // projection and lanes
  logic                 in_vld;
  logic signed [W-1:0]  p1_a [3];
  logic signed [W-1:0]  p2_a [3];
  logic                 pj_vld;
  logic signed [QW-1:0] q1_a [3];
  logic signed [QW-1:0] q2_a [3];
  logic signed [W-1:0]  p1_d [3];
  logic signed [W-1:0]  p2_d [3];
  epc_flag_t            f1;
  epc_flag_t            f2;
  logic [TW-1:0]        t1;
  logic [TW-1:0]        t2;

  // combine and soften
  logic [TW:0]          tsum;
  logic [TW-1:0]        dmean;
  logic [CW-1:0]        cb_d_q;
  logic                 cb_deg_q;
  logic                 cb_vld_q;
  logic [2*CW-1:0]      ml_ds_q;
  logic [CW:0]          ml_den_q;
  logic [CW-1:0]        ml_d_q;
  logic                 ml_byp_q;
  logic                 ml_deg_q;
  logic                 ml_vld_q;
  logic                 sd_vld;
  logic [CW-1:0]        sd_quo;
  logic [CW+1:0]        sd_side;
  logic                 done_q;
  logic [CW-1:0]        cost_q;
  logic                 deg_q;

  // register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = epc_reg_e'(paddr[CFG_AW-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        row_q[r] <= '0;
      end
      sigma_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ROW0:  row_q[0] <= pwdata[ROW_W-1:0];
        REG_ROW1:  row_q[1] <= pwdata[ROW_W-1:0];
        REG_ROW2:  row_q[2] <= pwdata[ROW_W-1:0];
        REG_SIGMA: sigma_q  <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ROW0:  prdata = CFG_DW'(row_q[0]);
      REG_ROW1:  prdata = CFG_DW'(row_q[1]);
      REG_ROW2:  prdata = CFG_DW'(row_q[2]);
      REG_SIGMA: prdata = CFG_DW'(sigma_q);
      default:   prdata = '0;
    endcase
  end

  // item intake
  assign busy   = 1'b0;
  assign in_vld = start && !busy;
  assign p1_a[0] = first_dir_x_i;
  assign p1_a[1] = first_dir_y_i;
  assign p1_a[2] = first_dir_z_i;
  assign p2_a[0] = second_dir_x_i;
  assign p2_a[1] = second_dir_y_i;
  assign p2_a[2] = second_dir_z_i;

  epc_proj #(
    .FRAC_BITS (FRAC_BITS)
  ) u_proj (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (in_vld),
    .p1_i   (p1_a),
    .p2_i   (p2_a),
    .row_i  (row_q),
    .vld_o  (pj_vld),
    .q1_o   (q1_a),
    .q2_o   (q2_a),
    .p1_o   (p1_d),
    .p2_o   (p2_d)
  );

  // first term scores q1 against the second direction
  epc_term #(
    .FRAC_BITS (FRAC_BITS)
  ) u_term1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (pj_vld),
    .q_i    (q1_a),
    .p_i    (p2_d),
    .flag_o (f1),
    .term_o (t1)
  );

  // second term scores q2 against the first direction
  epc_term #(
    .FRAC_BITS (FRAC_BITS)
  ) u_term2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (pj_vld),
    .q_i    (q2_a),
    .p_i    (p1_d),
    .flag_o (f2),
    .term_o (t2)
  );

  // mean of both terms, saturated to one
  assign tsum  = (TW + 1)'(t1) + (TW + 1)'(t2);
  assign dmean = tsum[TW:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cb_vld_q <= 1'b0;
      ml_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      cb_vld_q <= f1.vld;
      ml_vld_q <= cb_vld_q;
      done_q   <= sd_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    cb_d_q   <= (dmean > TW'(ONE_Q)) ? ONE_Q : dmean[CW-1:0];
    cb_deg_q <= f1.degen || f2.degen;
  end

  // softening operands d*s and d+s
  always_ff @(posedge clk_i) begin
    ml_ds_q  <= (2 * CW)'(cb_d_q) * (2 * CW)'(sigma_q);
    ml_den_q <= (CW + 1)'(cb_d_q) + (CW + 1)'(sigma_q);
    ml_d_q   <= cb_d_q;
    ml_byp_q <= (sigma_q == '0);
    ml_deg_q <= cb_deg_q;
  end

  epc_div #(
    .NW (2 * CW),
    .DW (CW + 1),
    .QW (CW),
    .SW (CW + 2)
  ) u_soft (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (ml_vld_q),
    .num_i  (ml_ds_q),
    .den_i  (ml_den_q),
    .side_i ({ml_deg_q, ml_byp_q, ml_d_q}),
    .vld_o  (sd_vld),
    .quo_o  (sd_quo),
    .side_o (sd_side)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (sd_side[CW+1]) begin
      cost_q <= ONE_Q;
    end else if (sd_side[CW]) begin
      cost_q <= sd_side[CW-1:0];
    end else begin
      cost_q <= sd_quo;
    end
    deg_q <= sd_side[CW+1];
  end

  assign done_o       = done_q;
  assign pair_cost_o  = cost_q;
  assign degenerate_o = deg_q;

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f1.vld == f2.vld)
    else $error("term lanes out of step");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("result missing after pipeline latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result without an accepted item");

  a_degen_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && degenerate_o) |-> (pair_cost_o == ONE_Q))
    else $error("degenerate item not saturated");

  a_cost_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pair_cost_o <= ONE_Q))
    else $error("cost above one");

endmodule

`default_nettype wire

// ===== test/tb_epipolar_pair_cost.sv =====
`timescale 1ns / 100ps

// scoreboard of predicted pair costs, oldest first
class pair_cost_board;
  logic [16:0] cost_q[$];
  logic        degen_q[$];
  int          errors;

  function new();
    errors = 0;
  endfunction

  function void note_item(logic [16:0] cost, logic degen);
    cost_q.insert(cost_q.size(), cost);
    degen_q.insert(degen_q.size(), degen);
  endfunction

  function void check_result(logic [16:0] cost, logic degen);
    logic [16:0] exp_cost;
    logic        exp_degen;
    if (cost_q.size() == 0) begin
      $display("%0t: unexpected result cost=%0d degen=%0d", $time, cost, degen);
      errors++;
      return;
    end
    exp_cost = cost_q.pop_front();
    exp_degen = degen_q.pop_front();
    if (exp_cost !== cost) begin
      $display("%0t: pair_cost expected %0d actual %0d", $time, exp_cost, cost);
      errors++;
    end
    if (exp_degen !== degen) begin
      $display("%0t: degenerate expected %0d actual %0d", $time, exp_degen, degen);
      errors++;
    end
  endfunction
endclass

module tb_epipolar_pair_cost;
  import epc_pkg::*;

  localparam int F = 16;
  localparam int W = F + 2;
  localparam int LAT = 82;
  localparam longint LIMIT = 1000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [W-1:0] p1x = '0, p1y = '0, p1z = '0, p2x = '0, p2y = '0, p2z = '0;
  logic done_o;
  logic [F:0] pair_cost_o;
  logic degenerate_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  // configuration copy used by the predictor
  logic [ROW_W-1:0] mrow[3];
  logic [F:0] sigma;
  pair_cost_board board;
  longint cycles = 0;
  bit calm = 0;

  epipolar_pair_cost dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .first_dir_x_i(p1x), .first_dir_y_i(p1y), .first_dir_z_i(p1z),
    .second_dir_x_i(p2x), .second_dir_y_i(p2y), .second_dir_z_i(p2z),
    .done_o(done_o), .pair_cost_o(pair_cost_o), .degenerate_o(degenerate_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // matrix entry as a signed value
  function automatic longint entry(int r, int c);
    logic signed [W-1:0] e;
    e = mrow[r][c*W +: W];
    return longint'(e);
  endfunction

  function automatic longint isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // normalized projection term, ok low on a zero vector
  function automatic void proj_term(input longint q[3], input longint p[3],
                                    output bit ok, output longint unsigned term);
    longint unsigned mag[3], mx, n2, len, adot;
    bit neg[3];
    longint dot, s;
    mx = 0; n2 = 0; dot = 0; term = 0;
    for (int k = 0; k < 3; k++) begin
      neg[k] = q[k] < 0;
      mag[k] = neg[k] ? -q[k] : q[k];
      if (mag[k] > mx) mx = mag[k];
    end
    ok = (mx != 0);
    if (!ok) return;
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int k = 0; k < 3; k++) mag[k] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int k = 0; k < 3; k++) mag[k] <<= 1;
    end
    for (int k = 0; k < 3; k++) begin
      s = neg[k] ? -longint'(mag[k]) : longint'(mag[k]);
      n2 += mag[k] * mag[k];
      dot += s * p[k];
    end
    len = isqrt(n2);
    adot = dot < 0 ? -dot : dot;
    term = adot / len;
  endfunction

  function automatic void predict_cost(output logic [F:0] cost, output logic degen);
    longint p1[3], p2[3], q1[3], q2[3];
    longint unsigned t1, t2, d;
    bit ok1, ok2;
    p1[0] = p1x; p1[1] = p1y; p1[2] = p1z;
    p2[0] = p2x; p2[1] = p2y; p2[2] = p2z;
    for (int i = 0; i < 3; i++) begin
      q1[i] = 0; q2[i] = 0;
      for (int j = 0; j < 3; j++) begin
        q1[i] += p1[j] * entry(j, i);
        q2[i] += entry(i, j) * p2[j];
      end
    end
    proj_term(q1, p2, ok1, t1);
    proj_term(q2, p1, ok2, t2);
    if (!ok1 || !ok2) begin
      cost = 17'h10000;
      degen = 1'b1;
      return;
    end
    d = (t1 + t2) >> 1;
    if (d > 65536) d = 65536;
    if (sigma != 0) d = (d * sigma) / (d + sigma);
    cost = d[F:0];
    degen = 1'b0;
  endfunction

  // result sampling and cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && done_o) board.check_result(pair_cost_o, degenerate_o);
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic reg_write(epc_reg_e idx, logic [CFG_DW-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= CFG_AW'(8 * int'(idx)); pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_SIGMA) sigma = val[F:0];
    else mrow[int'(idx)] = val[ROW_W-1:0];
  endtask

  task automatic drain();
    while (board.cost_q.size() != 0) @(posedge clk_i);
    repeat (LAT + 4) @(posedge clk_i);
  endtask

  task automatic idle_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat ($urandom_range(1, 11) - 1) @(negedge clk_i);
    end
  endtask

  // one item: drive at falling edge, wait for acceptance
  task automatic send_pair(logic [W-1:0] a, b, c, d, e, f);
    logic [F:0] cost;
    logic degen;
    idle_gap();
    @(negedge clk_i);
    p1x <= a; p1y <= b; p1z <= c; p2x <= d; p2y <= e; p2z <= f;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    predict_cost(cost, degen);
    board.note_item(cost, degen);
  endtask

  task automatic stop_items();
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  function automatic logic [W-1:0] rnd_comp();
    int m;
    m = $urandom_range(0, 9);
    if (m == 0) return W'($urandom);
    if (m == 1) return W'(65536);
    if (m == 2) return W'(-65536);
    return W'($urandom_range(0, 131072) - 65536);
  endfunction

  function automatic logic [ROW_W-1:0] rnd_row();
    logic [ROW_W-1:0] r;
    for (int c = 0; c < 3; c++) r[c*W +: W] = rnd_comp();
    if ($urandom_range(0, 7) == 0) r[W +: W] = '0;
    return r;
  endfunction

  task automatic rnd_config(int mode);
    logic [F:0] sg;
    for (int r = 0; r < 3; r++) reg_write(epc_reg_e'(r), CFG_DW'(rnd_row()));
    case (mode % 4)
      0: sg = 0;
      1: sg = 17'h10000;
      2: sg = 1;
      default: sg = $urandom_range(0, 65536);
    endcase
    reg_write(REG_SIGMA, CFG_DW'(sg));
  endtask

  task automatic rnd_item();
    send_pair(rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp());
  endtask

  localparam logic [W-1:0] PONE = W'(65536);
  localparam logic [W-1:0] NONE = W'(-65536);

  initial begin
    board = new();
    mrow[0] = '0; mrow[1] = '0; mrow[2] = '0; sigma = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero matrix after reset gives degenerate pairs
    send_pair(PONE, 0, 0, 0, PONE, 0);
    send_pair(NONE, NONE, NONE, PONE, PONE, PONE);
    stop_items();
    drain();

    // skew matrix of a translation along x, sigma off
    reg_write(REG_ROW0, 0);
    reg_write(REG_ROW1, CFG_DW'({W'(-65536), W'(0), W'(0)}));
    reg_write(REG_ROW2, CFG_DW'({W'(0), W'(65536), W'(0)}));
    reg_write(REG_SIGMA, 0);
    send_pair(PONE, 0, 0, PONE, 0, 0);
    send_pair(0, PONE, 0, 0, 0, PONE);
    send_pair(0, 0, PONE, 0, PONE, 0);
    send_pair(NONE, NONE, NONE, PONE, PONE, PONE);
    send_pair(W'(131071), W'(-131072), W'(1), W'(-1), W'(131071), W'(-131072));
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(0, PONE, PONE, 0, NONE, PONE);
    stop_items();
    drain();

    // extreme matrix and full sigma
    reg_write(REG_ROW0, {CFG_DW{1'b1}});
    reg_write(REG_ROW1, CFG_DW'({W'(131071), W'(-131072), W'(131071)}));
    reg_write(REG_ROW2, CFG_DW'({W'(-131072), W'(131071), W'(-131072)}));
    reg_write(REG_SIGMA, CFG_DW'(17'h10000));
    send_pair(PONE, PONE, PONE, PONE, NONE, PONE);
    send_pair(W'(131071), W'(131071), W'(131071), W'(-131072), W'(-131072), W'(-131072));
    send_pair(0, 0, PONE, PONE, 0, 0);
    stop_items();
    drain();
    reg_write(REG_SIGMA, 1);
    send_pair(PONE, 0, 0, 0, PONE, 0);
    send_pair(W'(12345), W'(-54321), W'(40000), W'(-3), W'(77777), W'(65535));
    stop_items();
    drain();

    // random phases with fresh configurations
    for (int ph = 0; ph < 16; ph++) begin
      rnd_config(ph);
      if (ph == 15) calm = 1;
      for (int n = 0; n < 100; n++) rnd_item();
      stop_items();
      drain();
    end

    if (board.errors == 0 && board.cost_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/epc_pkg.sv
src/epc_div.sv
src/epc_sqrt.sv
src/epc_proj.sv
src/epc_term.sv
src/epipolar_pair_cost.sv
test/tb_epipolar_pair_cost.sv
